FILE: src/nlv_pkg.sv
// ----------------------------------------------------------------------------
// nlv_pkg: shared types and constants for the numeric literal validator
// Character codes of the literal grammar and the item carried between stages.
// ----------------------------------------------------------------------------
package nlv_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned TdataW = 8;

    // characters of the grammar
    localparam logic [CharW-1:0] ChLowerE = 8'h65;
    localparam logic [CharW-1:0] ChUpperE = 8'h45;
    localparam logic [CharW-1:0] ChPoint  = 8'h2E;
    localparam logic [CharW-1:0] ChPlus   = 8'h2B;
    localparam logic [CharW-1:0] ChMinus  = 8'h2D;
    localparam logic [CharW-1:0] ChZero   = 8'h30;
    localparam logic [CharW-1:0] ChNine   = 8'h39;

    // one character item
    typedef struct packed {
        logic [CharW-1:0] char_code;
        logic             last_char;
    } char_item_t;

endpackage

FILE: src/nlv_recognizer.sv
// ----------------------------------------------------------------------------
// nlv_recognizer: phase register and transition logic of the literal grammar
// Advances one character per step and gives the verdict for a final character.
// ----------------------------------------------------------------------------
module nlv_recognizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  nlv_pkg::char_item_t item,
    output logic               verdict
);
    import nlv_pkg::*;

    typedef enum logic [3:0] {
        PhStart     = 4'd0,
        PhSign      = 4'd1,
        PhInt       = 4'd2,
        PhDotEmpty  = 4'd3,
        PhDotAfter  = 4'd4,
        PhFrac      = 4'd5,
        PhExpMark   = 4'd6,
        PhExpSign   = 4'd7,
        PhExpDigits = 4'd8,
        PhReject    = 4'd9
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t phase_step;

    logic is_dig;
    logic is_sgn;
    logic is_dot;
    logic is_exp;

    // character classes
    always_comb begin
        is_dig = (item.char_code >= ChZero) && (item.char_code <= ChNine);
        is_sgn = (item.char_code == ChPlus) || (item.char_code == ChMinus);
        is_dot = (item.char_code == ChPoint);
        is_exp = (item.char_code == ChLowerE) || (item.char_code == ChUpperE);
    end

    // transition table
    always_comb begin
        phase_step = PhReject;
        unique case (phase_reg)
            PhStart: begin
                if (is_sgn)      phase_step = PhSign;
                else if (is_dig) phase_step = PhInt;
            end
            PhSign: begin
                if (is_dig)      phase_step = PhInt;
                else if (is_dot) phase_step = PhDotEmpty;
            end
            PhInt: begin
                if (is_dig)      phase_step = PhInt;
                else if (is_dot) phase_step = PhDotAfter;
                else if (is_exp) phase_step = PhExpMark;
            end
            PhDotEmpty, PhDotAfter: begin
                if (is_dig)      phase_step = PhFrac;
            end
            PhFrac: begin
                if (is_dig)      phase_step = PhFrac;
                else if (is_exp) phase_step = PhExpMark;
            end
            PhExpMark: begin
                if (is_sgn)      phase_step = PhExpSign;
                else if (is_dig) phase_step = PhExpDigits;
            end
            PhExpSign, PhExpDigits: begin
                if (is_dig)      phase_step = PhExpDigits;
            end
            default: phase_step = PhReject;
        endcase
    end

    // accepting phases after this character
    assign verdict = (phase_step == PhInt) || (phase_step == PhDotAfter) ||
                     (phase_step == PhFrac) || (phase_step == PhExpDigits);

    // a final character sends the recognizer back to the start of a string
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            phase_next = item.last_char ? PhStart : phase_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PhStart;
        end else begin
            phase_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_final_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last_char |=> phase_reg == PhStart)
        else $error("phase did not return to start after a final character");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg))
        else $error("phase changed without a character");

    a_reject_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.last_char && phase_reg == PhReject |=> phase_reg == PhReject)
        else $error("rejected string left the reject phase");
`endif

endmodule

FILE: src/numeric_literal_validator.sv
// A final character passes the input register and then the verdict register before showing on m_tdata.
// Throughput: one character per cycle unless a final stalls; the phase updates once per item.
// A verdict waiting in the result register does not stall input until a second final arrives.
// Reset: aresetn low at a clock edge empties both registers and puts the phase at string start.
// ----------------------------------------------------------------------------
// numeric_literal_validator: decimal number literal recognizer
// Input register, grammar recognizer and verdict register; one verdict per string.
// ----------------------------------------------------------------------------
module numeric_literal_validator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nlv_pkg::CharW-1:0]   s_tdata,   // [7:0] char_code
    input  logic                        s_tlast,   // last_char
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nlv_pkg::TdataW-1:0]  m_tdata    // [0] is_number, [7:1] zero
);
    import nlv_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    char_item_t in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_bit_reg;
    logic       out_bit_next;
    logic       out_free;
    logic       advance;
    logic       verdict;

    // a character moves on unless it is final and the verdict slot is full
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_item_reg.last_char || out_free);
    assign s_tready = !in_valid_reg || advance;

    nlv_recognizer u_recognizer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    // next values of the two registers
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_item_reg.last_char) begin
            out_valid_next = 1'b1;
            out_bit_next   = verdict;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_item_reg.char_code <= s_tdata;
            in_item_reg.last_char <= s_tlast;
        end
        out_bit_reg <= out_bit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TdataW-1){1'b0}}, out_bit_reg};

`ifndef SYNTHESIS
    a_final_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.last_char |=> out_valid_reg)
        else $error("final character produced no verdict");

    a_blocked_final_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_item_reg.last_char && !out_free |=> in_valid_reg)
        else $error("final character dropped while verdict slot was full");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_bit_reg))
        else $error("pending verdict overwritten");
`endif

endmodule
